@@ hw/rtl/sitda_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and helpers for the signed integer to decimal ASCII converter.
package sitda_pkg;

    localparam int DATA_WIDTH_DEF = 32;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // Control for one BCD digit cell.
    typedef struct packed {
        logic clear;    // zero the digit at the start of a number
        logic convert;  // add-3 then shift one bit in from the cell below
        logic advance;  // take the digit of the cell below (move toward the top)
    } cell_ctrl_t;

    // Decimal digits of 2^(w-1), the largest magnitude: floor((w-1)*log10(2)) + 1.
    function automatic int digit_count(input int w);
        return ((w - 1) * 30103) / 100000 + 1;
    endfunction

endpackage

@@ hw/rtl/sitda_bcd_cell.sv @@
`timescale 1ns / 1ps
// One BCD digit cell of the shift-add-3 chain, also used to shift digits out.
module sitda_bcd_cell (
    input  logic                    aclk,
    input  sitda_pkg::cell_ctrl_t   ctrl,
    input  logic                    carry_in,
    output logic                    carry_out,
    input  logic [3:0]              digit_in,
    output logic [3:0]              digit_out
);

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    always_comb begin
        adj = (digit_reg >= 4'd5) ? (digit_reg + 4'd3) : digit_reg;
        priority if (ctrl.clear) begin
            digit_next = 4'd0;
        end else if (ctrl.convert) begin
            digit_next = {adj[2:0], carry_in};
        end else if (ctrl.advance) begin
            digit_next = digit_in;
        end else begin
            digit_next = digit_reg;
        end
    end

    assign carry_out = adj[3];
    assign digit_out = digit_reg;

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
    end

endmodule

@@ hw/rtl/signed_int_to_decimal_ascii.sv @@
`timescale 1ns / 1ps
// Converts a signed DATA_WIDTH-bit integer to its decimal ASCII text, most
// significant character first, one character per output beat, with m_last on
// the final one; negatives get a leading '-', zero gives "0", no leading zeros.
// The magnitude is shifted one bit per cycle through a row of BCD digit cells
// (shift-add-3), then the digits are shifted up the same row and read from the
// top cell. One number is in flight at a time; s_ready rises once the last
// character is in the output register.
module signed_int_to_decimal_ascii #(
    parameter int DATA_WIDTH = sitda_pkg::DATA_WIDTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [DATA_WIDTH-1:0] s_value,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [7:0]              m_character,
    output logic                    m_last
);

    localparam int NDIG = sitda_pkg::digit_count(DATA_WIDTH);
    localparam int BCW  = $clog2(DATA_WIDTH + 1);
    localparam int DCW  = $clog2(NDIG + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SIGN,
        ST_DIGITS
    } state_t;

    state_t                 state_reg;
    logic [DATA_WIDTH-1:0]  mag_reg;
    logic                   neg_reg;
    logic [BCW-1:0]         bit_cnt_reg;
    logic [DCW-1:0]         dig_cnt_reg;
    logic                   started_reg;
    logic                   m_valid_reg;
    logic [7:0]             m_character_reg;
    logic                   m_last_reg;

    logic                   accept;
    logic                   out_free;
    logic                   load_out;
    logic                   is_last;
    logic                   skip;
    logic [3:0]             top_digit;
    sitda_pkg::cell_ctrl_t  ctrl;

    logic [3:0]             digit [NDIG];
    logic                   carry [NDIG];

    assign s_ready     = (state_reg == ST_IDLE);
    assign accept      = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign top_digit   = digit[NDIG-1];
    assign is_last     = (dig_cnt_reg == DCW'(1));
    // leading zero: drop it without emitting, but never the units digit
    assign skip        = !started_reg && (top_digit == 4'd0) && !is_last;
    // a new beat goes into the output register this cycle
    assign load_out    = out_free && ((state_reg == ST_SIGN) ||
                                      ((state_reg == ST_DIGITS) && !skip));

    assign m_valid     = m_valid_reg;
    assign m_character = m_character_reg;
    assign m_last      = m_last_reg;

    always_comb begin
        ctrl.clear   = accept;
        ctrl.convert = (state_reg == ST_CONVERT);
        ctrl.advance = (state_reg == ST_DIGITS) && (skip || out_free);
    end

    assign carry[0] = mag_reg[DATA_WIDTH-1];

    genvar i;
    generate
        for (i = 0; i < NDIG; i++) begin : g_cell
            if (i == NDIG - 1) begin : g_top
                sitda_bcd_cell u_cell (
                    .aclk      (aclk),
                    .ctrl      (ctrl),
                    .carry_in  (carry[i]),
                    .carry_out (),
                    .digit_in  ((i == 0) ? 4'd0 : digit[(i == 0) ? 0 : i-1]),
                    .digit_out (digit[i])
                );
            end else begin : g_mid
                sitda_bcd_cell u_cell (
                    .aclk      (aclk),
                    .ctrl      (ctrl),
                    .carry_in  (carry[i]),
                    .carry_out (carry[i+1]),
                    .digit_in  ((i == 0) ? 4'd0 : digit[(i == 0) ? 0 : i-1]),
                    .digit_out (digit[i])
                );
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            bit_cnt_reg <= '0;
            dig_cnt_reg <= '0;
            started_reg <= 1'b0;
        end else begin
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        neg_reg     <= s_value[DATA_WIDTH-1];
                        // two's complement negate; most negative wraps to 2^(W-1)
                        mag_reg     <= s_value[DATA_WIDTH-1] ?
                                       (~s_value + DATA_WIDTH'(1)) : s_value;
                        bit_cnt_reg <= BCW'(DATA_WIDTH);
                        state_reg   <= ST_CONVERT;
                    end
                end
                ST_CONVERT: begin
                    mag_reg     <= {mag_reg[DATA_WIDTH-2:0], 1'b0};
                    bit_cnt_reg <= bit_cnt_reg - BCW'(1);
                    if (bit_cnt_reg == BCW'(1)) begin
                        dig_cnt_reg <= DCW'(NDIG);
                        started_reg <= 1'b0;
                        state_reg   <= neg_reg ? ST_SIGN : ST_DIGITS;
                    end
                end
                ST_SIGN: begin
                    if (out_free) begin
                        m_character_reg <= sitda_pkg::CHAR_MINUS;
                        m_last_reg      <= 1'b0;
                        state_reg       <= ST_DIGITS;
                    end
                end
                ST_DIGITS: begin
                    if (skip) begin
                        dig_cnt_reg <= dig_cnt_reg - DCW'(1);
                    end else if (out_free) begin
                        m_character_reg <= sitda_pkg::CHAR_ZERO | {4'd0, top_digit};
                        m_last_reg      <= is_last;
                        started_reg     <= 1'b1;
                        dig_cnt_reg     <= dig_cnt_reg - DCW'(1);
                        if (is_last) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/sitda_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the integer to decimal ASCII converter, bound to the top level.
module sitda_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_character,
    input logic       m_last
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_character) && $stable(m_last))
        else $error("output beat changed while stalled");

    a_char_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_character == sitda_pkg::CHAR_MINUS) ||
                    ((m_character >= sitda_pkg::CHAR_ZERO) &&
                     (m_character <= (sitda_pkg::CHAR_ZERO + 8'd9))))
        else $error("character outside '-' and digits");

    // the sign never ends a number
    a_minus_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_character == sitda_pkg::CHAR_MINUS) |-> !m_last)
        else $error("minus sign flagged as last");

    // one number at a time: busy right after an accepted input
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted back to back");

endmodule

bind signed_int_to_decimal_ascii sitda_checker u_sitda_checker (.*);
